FILE: rtl/rws_pkg.sv
// Shared types and constants for the roulette-wheel member selector.
// Used by every module of the block except rws_mem; depends on nothing.
package rws_pkg;

	// Default sizing of the population table
	localparam int MEMBERS_DEF      = 64;
	localparam int FITNESS_BITS_DEF = 16;

	// Fixed field widths of the ports
	localparam int IDX_BITS    = 6;
	localparam int CNT_BITS    = 7;
	localparam int FIT_IN_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int MASK_BITS   = 64;
	localparam int STATUS_BITS = 2;

	// Member count after reset
	localparam logic [CNT_BITS-1:0] COUNT_RESET = 7'd64;

	// Command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	// Status codes of a result word
	localparam logic [STATUS_BITS-1:0] STAT_PICKED    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_WRITTEN   = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_RANGE_ERR = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_TOTAL,
		S_MUL,
		S_SCALE,
		S_WALK,
		S_DONE
	} state_t;

	// Operations of the shared adder unit
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_ACC,
		OP_MAC,
		OP_SAVE_TOTAL,
		OP_SAVE_SCALED
	} unit_op_t;

	// Control from the sequencer to the adder unit
	typedef struct packed {
		unit_op_t op;
		logic     frac_bit;
		logic     add_en;
	} unit_ctrl_t;

	// Finished result handed from the sequencer to the output register
	typedef struct packed {
		logic                   valid;
		logic [IDX_BITS-1:0]    pick;
		logic [STATUS_BITS-1:0] status;
	} res_t;

endpackage

FILE: rtl/rws_mem.sv
// Fitness table: one write port, one read port with registered read data.
// Depends on nothing; contents are undefined until written.
module rws_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int ADDR_BITS = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Store one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read one entry, data valid next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

FILE: rtl/rws_unit.sv
// Shared adder unit: accumulates fitness sums, runs the shift-add multiply
// of fraction by total, and compares the running sum. Uses rws_pkg.
module rws_unit #(
	parameter int FITNESS_BITS = 16,
	parameter int SUM_BITS = 22
) (
	input  logic                     clk,
	input  rws_pkg::unit_ctrl_t      ctrl,
	input  logic [FITNESS_BITS-1:0]  entry,
	output logic                     hit
);
	import rws_pkg::*;

	localparam int PROD_BITS = SUM_BITS + FRAC_BITS;

	logic [PROD_BITS-1:0] acc_q;
	logic [SUM_BITS-1:0]  total_q;
	logic [SUM_BITS-1:0]  scaled_q;
	logic [PROD_BITS-1:0] op_a;
	logic [PROD_BITS-1:0] op_b;
	logic [PROD_BITS-1:0] sum;

	// Select adder operands: plain accumulate or one multiply step
	always_comb begin
		if (ctrl.op == OP_MAC) begin
			op_a = {acc_q[PROD_BITS-2:0], 1'b0};
			op_b = ctrl.frac_bit ? PROD_BITS'(total_q) : '0;
		end else begin
			op_a = acc_q;
			op_b = ctrl.add_en ? PROD_BITS'(entry) : '0;
		end
		sum = op_a + op_b;
		hit = (ctrl.op == OP_ACC) && ctrl.add_en && (scaled_q <= sum[SUM_BITS-1:0]);
	end

	// Update accumulator, total and scaled target
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_CLEAR: begin
				acc_q <= '0;
			end
			OP_ACC, OP_MAC: begin
				acc_q <= sum;
			end
			OP_SAVE_TOTAL: begin
				total_q <= acc_q[SUM_BITS-1:0];
				acc_q   <= '0;
			end
			OP_SAVE_SCALED: begin
				scaled_q <= acc_q[PROD_BITS-1:FRAC_BITS];
				acc_q    <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/rws_seq.sv
// Sequencer: takes input words, writes the fitness table, and steps a select
// through sum, multiply and walk passes. Uses rws_pkg, drives rws_unit/rws_mem.
module rws_seq #(
	parameter int MEMBERS = 64,
	parameter int FITNESS_BITS = 16,
	parameter int ADDR_BITS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [rws_pkg::CNT_BITS-1:0]        member_count,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [rws_pkg::IDX_BITS-1:0]        member_index,
	input  logic [rws_pkg::FIT_IN_BITS-1:0]     fitness_value,
	input  logic [rws_pkg::FRAC_BITS-1:0]       random_fraction,
	input  logic [rws_pkg::MASK_BITS-1:0]       drop_mask,
	output logic                                mem_we,
	output logic [ADDR_BITS-1:0]                mem_waddr,
	output logic [FITNESS_BITS-1:0]             mem_wdata,
	output logic                                mem_re,
	output logic [ADDR_BITS-1:0]                mem_raddr,
	output rws_pkg::unit_ctrl_t                 ctrl,
	input  logic                                hit,
	output rws_pkg::res_t                       res,
	input  logic                                res_ready
);
	import rws_pkg::*;

	localparam int BIT_CNT_BITS = $clog2(FRAC_BITS);
	localparam logic [BIT_CNT_BITS-1:0] BIT_LAST = BIT_CNT_BITS'(FRAC_BITS - 1);
	localparam logic [CNT_BITS-1:0] MEMBERS_CNT = CNT_BITS'(MEMBERS);

	state_t                  state_q;
	state_t                  state_next;
	logic [CNT_BITS-1:0]     count_q;
	logic [CNT_BITS-1:0]     iss_q;
	logic [BIT_CNT_BITS-1:0] bit_q;
	logic [FRAC_BITS-1:0]    frac_q;
	logic [MASK_BITS-1:0]    mask_q;
	logic                    rd_v_s1;
	logic [IDX_BITS-1:0]     rd_idx_s1;
	logic [IDX_BITS-1:0]     pick_q;
	logic [STATUS_BITS-1:0]  stat_q;
	logic [CNT_BITS-1:0]     used;
	logic                    range_err;
	logic                    idx_ok;
	logic                    issue;
	logic                    fresh;
	logic                    accept;

	// Clamp the configured member count and check drop bits beyond it
	always_comb begin
		if (member_count == '0) begin
			used = CNT_BITS'(1);
		end else if (member_count > MEMBERS_CNT) begin
			used = MEMBERS_CNT;
		end else begin
			used = member_count;
		end
		range_err = |(drop_mask & ({MASK_BITS{1'b1}} << used));
		idx_ok    = {1'b0, member_index} < MEMBERS_CNT;
	end

	assign accept    = in_valid && in_ready;
	assign issue     = iss_q < count_q;
	assign fresh     = rd_v_s1 && !mask_q[rd_idx_s1];
	assign mem_we    = accept && (command == CMD_WRITE) && idx_ok;
	assign mem_waddr = member_index[ADDR_BITS-1:0];
	assign mem_wdata = FITNESS_BITS'(fitness_value);
	assign mem_raddr = iss_q[ADDR_BITS-1:0];

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and per-state controls
	always_comb begin
		state_next    = state_q;
		in_ready      = 1'b0;
		mem_re        = 1'b0;
		ctrl.op       = OP_HOLD;
		ctrl.frac_bit = frac_q[FRAC_BITS-1];
		ctrl.add_en   = 1'b0;
		res.valid     = 1'b0;
		res.pick      = pick_q;
		res.status    = stat_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ctrl.op  = OP_CLEAR;
				if (in_valid) begin
					if (command == CMD_WRITE || range_err || used == CNT_BITS'(1)) begin
						state_next = S_DONE;
					end else begin
						state_next = S_SUM;
					end
				end
			end
			S_SUM: begin
				mem_re      = issue;
				ctrl.op     = OP_ACC;
				ctrl.add_en = fresh;
				if (!issue && !rd_v_s1) begin
					state_next = S_TOTAL;
				end
			end
			S_TOTAL: begin
				ctrl.op    = OP_SAVE_TOTAL;
				state_next = S_MUL;
			end
			S_MUL: begin
				ctrl.op = OP_MAC;
				if (bit_q == BIT_LAST) begin
					state_next = S_SCALE;
				end
			end
			S_SCALE: begin
				ctrl.op    = OP_SAVE_SCALED;
				state_next = S_WALK;
			end
			S_WALK: begin
				mem_re      = issue;
				ctrl.op     = OP_ACC;
				ctrl.add_en = fresh;
				if (hit || (!issue && !rd_v_s1)) begin
					state_next = S_DONE;
				end
			end
			S_DONE: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Advance counters and the read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			iss_q   <= '0;
			bit_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
			if (accept) begin
				count_q <= used;
				iss_q   <= '0;
				bit_q   <= '0;
			end else if (mem_re) begin
				iss_q <= iss_q + CNT_BITS'(1);
			end else if (state_q == S_SCALE) begin
				iss_q <= '0;
			end
			if (state_q == S_MUL) begin
				bit_q <= bit_q + BIT_CNT_BITS'(1);
			end
		end
	end

	// Capture the item and the result fields
	always_ff @(posedge clk) begin
		rd_idx_s1 <= iss_q[IDX_BITS-1:0];
		if (accept) begin
			frac_q <= random_fraction;
			mask_q <= drop_mask;
			pick_q <= '0;
			if (command == CMD_WRITE) begin
				stat_q <= STAT_WRITTEN;
			end else if (range_err) begin
				stat_q <= STAT_RANGE_ERR;
			end else begin
				stat_q <= STAT_PICKED;
			end
		end else if (state_q == S_MUL) begin
			frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
		end else if (state_q == S_WALK && hit) begin
			pick_q <= rd_idx_s1;
		end
	end

endmodule

FILE: rtl/roulette_wheel_selector_core.sv
// Roulette-wheel selector: takes a new word only once the result of the last
// one has been handed to the output register. A write word, a range error or a
// single member in use goes straight to the result; any other select makes two
// passes over the single table read port plus a 16-step shift-add multiply; a
// stalled output holds the block.
// Reset idles the sequencer and sets member_count to 64; the table is not cleared.
module roulette_wheel_selector_core #(
	parameter int MEMBERS = rws_pkg::MEMBERS_DEF,
	parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rws_pkg::CNT_BITS-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [rws_pkg::IDX_BITS-1:0]       member_index,
	input  logic [rws_pkg::FIT_IN_BITS-1:0]    fitness_value,
	input  logic [rws_pkg::FRAC_BITS-1:0]      random_fraction,
	input  logic [rws_pkg::MASK_BITS-1:0]      drop_mask,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rws_pkg::IDX_BITS-1:0]       picked_index,
	output logic [rws_pkg::STATUS_BITS-1:0]    status
);
	import rws_pkg::*;

	localparam int ADDR_BITS = $clog2(MEMBERS);
	localparam int SUM_BITS  = FITNESS_BITS + ADDR_BITS;

	logic [CNT_BITS-1:0]     member_count_q;
	logic                    out_valid_q;
	logic [IDX_BITS-1:0]     picked_q;
	logic [STATUS_BITS-1:0]  status_q;
	logic                    mem_we;
	logic [ADDR_BITS-1:0]    mem_waddr;
	logic [FITNESS_BITS-1:0] mem_wdata;
	logic                    mem_re;
	logic [ADDR_BITS-1:0]    mem_raddr;
	logic [FITNESS_BITS-1:0] mem_rdata;
	unit_ctrl_t              ctrl;
	logic                    hit;
	res_t                    res;
	logic                    res_ready;

	// Member count register, writable at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			member_count_q <= cfg_data;
		end
	end

	rws_seq #(
		.MEMBERS(MEMBERS),
		.FITNESS_BITS(FITNESS_BITS),
		.ADDR_BITS(ADDR_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.member_count(member_count_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.member_index(member_index),
		.fitness_value(fitness_value),
		.random_fraction(random_fraction),
		.drop_mask(drop_mask),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.ctrl(ctrl),
		.hit(hit),
		.res(res),
		.res_ready(res_ready)
	);

	rws_mem #(
		.DEPTH(MEMBERS),
		.WIDTH(FITNESS_BITS),
		.ADDR_BITS(ADDR_BITS)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	rws_unit #(
		.FITNESS_BITS(FITNESS_BITS),
		.SUM_BITS(SUM_BITS)
	) u_unit (
		.clk(clk),
		.ctrl(ctrl),
		.entry(mem_rdata),
		.hit(hit)
	);

	// Output register: load a finished word when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			picked_q <= res.pick;
			status_q <= res.status;
		end
	end

	assign out_valid    = out_valid_q;
	assign picked_index = picked_q;
	assign status       = status_q;

endmodule

FILE: rtl/rws_checker.sv
// Port-level checks of the roulette-wheel selector, bound to the top level.
// Uses rws_pkg; sees only the ports of roulette_wheel_selector_core.
module rws_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [rws_pkg::IDX_BITS-1:0]       picked_index,
	input logic [rws_pkg::STATUS_BITS-1:0]    status
);
	import rws_pkg::*;

	// A stalled result word holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(picked_index) && $stable(status))
		else $error("result word changed while stalled");

	// A waiting input word is not withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input valid dropped before accept");

	// Ready drops in the cycle after the block takes a word
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after accept");

	// Only defined status codes appear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_PICKED || status == STAT_WRITTEN ||
			status == STAT_RANGE_ERR))
		else $error("undefined status code");

	// Writes and range errors report member zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_PICKED |-> picked_index == '0)
		else $error("nonzero index on write or error result");

endmodule

bind roulette_wheel_selector_core rws_checker u_rws_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.picked_index(picked_index),
	.status(status)
);

FILE: tb/roulette_wheel_selector_core_test.sv
// Self-checking testbench for the roulette-wheel member selector core.
// Depends on rws_pkg and roulette_wheel_selector_core. It keeps its own copy
// of the fitness table and the member count to predict every result word.
module roulette_wheel_selector_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rws_pkg::*;

	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned TAIL_CYCLES = 40;

	typedef struct packed {
		logic [IDX_BITS-1:0]    pick;
		logic [STATUS_BITS-1:0] status;
	} selection_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CNT_BITS-1:0]    cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   command;
	logic [IDX_BITS-1:0]    member_index;
	logic [FIT_IN_BITS-1:0] fitness_value;
	logic [FRAC_BITS-1:0]   random_fraction;
	logic [MASK_BITS-1:0]   drop_mask;
	logic                   out_valid;
	logic                   out_ready;
	logic [IDX_BITS-1:0]    picked_index;
	logic [STATUS_BITS-1:0] status;

	// Shadow state of the block
	logic [FIT_IN_BITS-1:0] fitness_shadow [MEMBERS_DEF];
	logic [CNT_BITS-1:0]    count_shadow = COUNT_RESET;

	selection_t  awaited_q [$];
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	bit          tx_idle_on = 1'b0;
	bit          rx_idle_on = 1'b0;
	bit          hold_req = 1'b0;

	roulette_wheel_selector_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.member_index   (member_index),
		.fitness_value  (fitness_value),
		.random_fraction(random_fraction),
		.drop_mask      (drop_mask),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.picked_index   (picked_index),
		.status         (status)
	);

	always #2 clk = ~clk;

	// Clamp the configured count to between one and the table size
	function automatic int unsigned members_in_use();
		if (count_shadow == 0) return 1;
		if (count_shadow > MEMBERS_DEF) return MEMBERS_DEF;
		return count_shadow;
	endfunction

	// Apply one word to the shadow table and work out its result
	function automatic selection_t predict_selection(logic cmd, logic [IDX_BITS-1:0] idx,
			logic [FIT_IN_BITS-1:0] fit, logic [FRAC_BITS-1:0] frac,
			logic [MASK_BITS-1:0] mask);
		selection_t      r;
		int unsigned     n;
		longint unsigned total;
		longint unsigned scaled;
		longint unsigned run;
		r.pick = '0;
		r.status = STAT_PICKED;
		if (cmd == CMD_WRITE) begin
			fitness_shadow[idx] = fit;
			r.status = STAT_WRITTEN;
			return r;
		end
		n = members_in_use();
		if (n < 64 && (mask >> n) != 0) begin
			r.status = STAT_RANGE_ERR;
			return r;
		end
		if (n > 1) begin
			total = 0;
			for (int i = 0; i < n; i++)
				if (!mask[i]) total += fitness_shadow[i];
			scaled = ({48'd0, frac} * total) >> 16;
			run = 0;
			for (int i = 0; i < n; i++) begin
				if (!mask[i]) begin
					run += fitness_shadow[i];
					if (scaled <= run) begin
						r.pick = IDX_BITS'(i);
						break;
					end
				end
			end
		end
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_gap();
		if ($urandom_range(0, 15) == 0) return $urandom_range(12, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [MASK_BITS-1:0] draw_drop_mask(int unsigned n);
		logic [MASK_BITS-1:0] m;
		m = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: m = m & {$urandom, $urandom} & {$urandom, $urandom};
			1: m = m | {$urandom, $urandom};
			2: m = '0;
			default: ;
		endcase
		if (n < 64) begin
			m &= (64'd1 << n) - 64'd1;
			// occasionally set a bit past the population
			if ($urandom_range(0, 9) == 0) m |= 64'd1 << $urandom_range(n, 63);
		end
		return m;
	endfunction

	function automatic logic [15:0] draw_value();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one word and wait until it is taken; valid stays high afterwards
	task automatic send_word(logic cmd, logic [IDX_BITS-1:0] idx, logic [FIT_IN_BITS-1:0] fit,
			logic [FRAC_BITS-1:0] frac, logic [MASK_BITS-1:0] mask);
		int unsigned gap;
		selection_t  expected;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = idle_gap();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		command         <= cmd;
		member_index    <= idx;
		fitness_value   <= fit;
		random_fraction <= frac;
		drop_mask       <= mask;
		do @(posedge clk); while (!in_ready);
		expected = predict_selection(cmd, idx, fit, frac, mask);
		awaited_q = {awaited_q, expected};
	endtask

	task automatic write_fitness(logic [IDX_BITS-1:0] idx, logic [FIT_IN_BITS-1:0] fit);
		send_word(CMD_WRITE, idx, fit, 16'($urandom), {$urandom, $urandom});
	endtask

	task automatic select_member(logic [FRAC_BITS-1:0] frac, logic [MASK_BITS-1:0] mask);
		send_word(CMD_SELECT, 6'($urandom), 16'($urandom), frac, mask);
	endtask

	task automatic send_random_word();
		if ($urandom_range(0, 4) == 0)
			write_fitness(6'($urandom), draw_value());
		else
			select_member(draw_value(), draw_drop_mask(members_in_use()));
	endtask

	// Drop valid and wait for every outstanding result word
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_q.size() != 0);
	endtask

	task automatic set_member_count(logic [CNT_BITS-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_shadow = value;
	endtask

	// Write every entry once so no select reads an unwritten entry
	task automatic fill_fitness_table();
		write_fitness(6'd0, 16'hFFFF);
		for (int i = 1; i < MEMBERS_DEF - 1; i++) write_fitness(6'(i), draw_value());
		write_fitness(6'd63, 16'h0000);
	endtask

	task automatic test_selection_edges();
		select_member(16'h0000, 64'd0);
		select_member(16'hFFFF, 64'd0);
		select_member(16'h8000, '1);
		select_member(16'hFFFF, ~(64'd1 << 63));
		select_member(16'h0000, 64'd1);
		select_member(16'h5A5A, 64'hAAAA_AAAA_AAAA_AAAA);
	endtask

	task automatic test_count_limits();
		set_member_count(7'd8);
		select_member(16'h1234, 64'h100);
		select_member(16'h1234, 64'd1 << 63);
		select_member(16'h8000, 64'hFF);
		select_member(16'h8000, 64'd0);
		set_member_count(7'd1);
		select_member(16'hFFFF, 64'd0);
		select_member(16'hFFFF, 64'd2);
		select_member(16'hFFFF, 64'd1);
		set_member_count(7'd0);
		select_member(16'h4321, 64'd0);
		select_member(16'h4321, 64'd2);
		set_member_count(7'd127);
		select_member(16'h1234, 64'd1 << 63);
		// zero total picks the first member still in play
		set_member_count(7'd2);
		write_fitness(6'd0, 16'h0000);
		write_fitness(6'd1, 16'h0000);
		select_member(16'hFFFF, 64'd0);
		select_member(16'hFFFF, 64'd1);
		write_fitness(6'd0, 16'hFFFF);
		write_fitness(6'd1, 16'hFFFF);
		select_member(16'hFFFF, 64'd0);
		select_member(16'h0000, 64'd0);
	endtask

	task automatic test_random_traffic();
		logic [CNT_BITS-1:0] counts [12];
		counts = '{7'd64, 7'd2, 7'd8, 7'd1, 7'd33, 7'd0, 7'd16, 7'd127, 7'd3,
			7'd5, 7'd64, 7'd0};
		counts[9] = 7'($urandom_range(1, 64));
		for (int p = 0; p < 12; p++) begin
			set_member_count(counts[p]);
			tx_idle_on = (p % 3) != 0;
			rx_idle_on = (p % 4) != 1;
			repeat (150) send_random_word();
		end
	endtask

	// Hold the result side for a long stretch while words keep coming
	task automatic test_output_backpressure();
		set_member_count(7'd4);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_req = 1'b1;
		repeat (24) send_random_word();
		drain();
	endtask

	// Result side ready: random stalls and the long hold-off
	initial begin : drive_out_ready
		int unsigned n;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				n = idle_gap();
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin : check_results
		selection_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_q.size() == 0) begin
				$error("result word with none expected: picked_index %0d status %0d",
					picked_index, status);
				error_count++;
			end else begin
				want = awaited_q.pop_front();
				if (picked_index !== want.pick) begin
					$error("picked_index mismatch: expected %0d, actual %0d",
						want.pick, picked_index);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status, status);
					error_count++;
				end
			end
		end
	end

	// End the run when no handshake completes for too long
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : run_tests
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		command         = CMD_WRITE;
		member_index    = '0;
		fitness_value   = '0;
		random_fraction = '0;
		drop_mask       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_fitness_table();
		test_selection_edges();
		test_count_limits();
		test_random_traffic();
		test_output_backpressure();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && awaited_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
